// File: rtl/kss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and constants for the shared-store stack block.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_W     = 32;
  localparam int STACK_ID_W = 2;
  localparam int STACKS     = 1 << STACK_ID_W;

  localparam int IDX_W = $clog2(DEPTH);  // address of one store entry
  localparam int PTR_W = IDX_W + 1;      // entry index or null

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(DEPTH);

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // input word: action, stack_id, push_value
  localparam int IN_BITS   = ACTION_W + STACK_ID_W + DATA_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // output word: read_value, status, store_full, stack_empty
  localparam int OUT_BITS   = DATA_W + STATUS_W + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [PTR_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } link_rd_t;

endpackage : kss_pkg
`default_nettype wire

// File: rtl/kss_link_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kss_link_mem
// Link store: synchronous RAM (registered read) plus a fill count. Entries at or
// above the fill count were never written and read back as index + 1.
// ----------------------------------------------------------------------------
module kss_link_mem (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire kss_pkg::link_rd_t rd_i,
  output logic [kss_pkg::PTR_W-1:0] rd_data_o,
  input  wire kss_pkg::link_wr_t wr_i
);
  import kss_pkg::*;

  logic [PTR_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] mem_rd_q;
  logic [PTR_W-1:0] fresh_val_q;
  logic             fresh_q;
  logic [PTR_W-1:0] fill_q, fill_d;

  // writes always land at or below the fill count
  always_comb begin
    fill_d = fill_q;
    if (wr_i.en && ({1'b0, wr_i.addr} == fill_q)) begin
      fill_d = fill_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      mem_rd_q    <= mem[rd_i.addr];
      fresh_q     <= ({1'b0, rd_i.addr} >= fill_q);
      fresh_val_q <= {1'b0, rd_i.addr} + PTR_W'(1);
    end
  end

  assign rd_data_o = fresh_q ? fresh_val_q : mem_rd_q;

endmodule : kss_link_mem
`default_nettype wire

// File: rtl/k_stacks_shared_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_stacks_shared_store
// Four LIFO stacks sharing one data store, chained through a link store
// that also holds the free list.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one word per operation - push, pop or peek on
//   one stack. Output stream (m_axis): exactly one result word per input
//   word, in order: value, status, store-full and stack-empty flags.
//
//   Operation: in the accept cycle the free head or the stack top addresses
//   the link store and data store (registered read); in the next cycle the
//   read data comes back and, unless the output stalls, the link store is
//   written back and the result is loaded into the output register. The
//   next word is taken in the cycle after write-back, so no word is accepted
//   before the one ahead of it has been written back.
//
//   Output stall: the output register holds a finished result while the
//   next word is accepted and read. If it is still full at write-back,
//   the block waits in that step until the receiver takes the result.
//
//   Reset: all stacks empty, free list starts at entry 0. No clearing
//   pass is needed: the link store keeps a fill count and serves never
//   written entries as "next index". The data store is not initialized.
// ----------------------------------------------------------------------------
module k_stacks_shared_store (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // [1:0] action, [3:2] stack_id, [35:4] push_value, [39:36] zero
  input  wire  [kss_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] read_value, [33:32] status, [34] store_full, [35] stack_empty,
  // [39:36] zero
  output logic [kss_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready
);
  import kss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // input word fields
  logic [ACTION_W-1:0]   in_action;
  logic [STACK_ID_W-1:0] in_sid;
  logic [DATA_W-1:0]     in_value;
  assign in_action = s_axis_tdata[ACTION_W-1:0];
  assign in_sid    = s_axis_tdata[ACTION_W +: STACK_ID_W];
  assign in_value  = s_axis_tdata[ACTION_W+STACK_ID_W +: DATA_W];

  // architectural pointers
  logic [PTR_W-1:0] tops_q [STACKS];
  logic [PTR_W-1:0] free_head_q, free_head_d;
  logic [PTR_W-1:0] top_new;
  logic             top_we;

  // operation latched at accept
  action_e               op_q;
  logic [STACK_ID_W-1:0] sid_q;
  logic [DATA_W-1:0]     val_q;
  logic [PTR_W-1:0]      top_q;
  logic [PTR_W-1:0]      fh_q;

  // memories
  logic [DATA_W-1:0] data_mem [DEPTH];
  logic [DATA_W-1:0] data_rd_q;
  logic              data_we;
  link_rd_t          link_rd;
  link_wr_t          link_wr;
  logic [PTR_W-1:0]  link_val;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic accept, commit;
  logic [PTR_W-1:0] in_top;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign in_top        = tops_q[in_sid];

  // read address: free head for push, stack top otherwise
  always_comb begin
    link_rd.en   = 1'b0;
    link_rd.addr = in_top[IDX_W-1:0];
    if (accept) begin
      if (in_action == ACT_PUSH) begin
        link_rd.addr = free_head_q[IDX_W-1:0];
        link_rd.en   = (free_head_q != NIL_PTR);
      end else begin
        link_rd.en   = (in_top != NIL_PTR);
      end
    end
  end

  kss_link_mem u_link (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (link_rd),
    .rd_data_o (link_val),
    .wr_i      (link_wr)
  );

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[fh_q[IDX_W-1:0]] <= val_q;
    end
    if (link_rd.en) begin
      data_rd_q <= data_mem[link_rd.addr];
    end
  end

  // write-back step
  always_comb begin
    logic [DATA_W-1:0]   rv;
    status_e             st;
    logic [PTR_W-1:0]    top_after;

    rv          = '0;
    st          = ST_OK;
    free_head_d = free_head_q;
    top_new     = top_q;
    top_we      = 1'b0;
    data_we     = 1'b0;
    link_wr.en   = 1'b0;
    link_wr.addr = fh_q[IDX_W-1:0];
    link_wr.data = top_q;

    case (op_q)
      ACT_PUSH: begin
        if (fh_q == NIL_PTR) begin
          st = ST_OVERFLOW;
        end else begin
          free_head_d = link_val;
          top_new     = fh_q;
          top_we      = commit;
          data_we     = commit;
          link_wr.en  = commit;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (top_q == NIL_PTR) begin
          rv = '1;
          st = ST_EMPTY;
        end else begin
          rv = data_rd_q;
          if (op_q == ACT_POP) begin
            top_new      = link_val;
            top_we       = commit;
            free_head_d  = top_q;
            link_wr.en   = commit;
            link_wr.addr = top_q[IDX_W-1:0];
            link_wr.data = fh_q;
          end
        end
      end
      default: begin
      end
    endcase

    top_after = top_new;

    out_data_d = '0;
    out_data_d[DATA_W-1:0]            = rv;
    out_data_d[DATA_W +: STATUS_W]    = st;
    out_data_d[DATA_W+STATUS_W]       = (free_head_d == NIL_PTR);
    out_data_d[DATA_W+STATUS_W+1]     = (top_after == NIL_PTR);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      free_head_q <= '0;
      for (int i = 0; i < STACKS; i++) begin
        tops_q[i] <= NIL_PTR;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        free_head_q <= free_head_d;
      end
      if (top_we) begin
        tops_q[sid_q] <= top_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= action_e'(in_action);
      sid_q <= in_sid;
      val_q <= in_value;
      top_q <= in_top;
      fh_q  <= free_head_q;
    end
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule : k_stacks_shared_store
`default_nettype wire
